### rtl/hpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package hpq_pkg;

    // Number of entries the heap can hold.
    localparam int CAPACITY = 127;

    // Slot address and count width, and the wider child index that can hold 2*CAPACITY.
    localparam int AW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 1;

    localparam int KEY_W      = 32;
    localparam int PAY_W      = 16;
    localparam int CNT_OUT_W  = 7;

    typedef logic [AW-1:0] t_addr;
    typedef logic [AW-1:0] t_cnt;
    typedef logic [IW-1:0] t_idx;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_entry;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Datapath action selected by the current microinstruction.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_INS_START,
        ACT_RD_PARENT,
        ACT_UP_MOVE,
        ACT_WR_ENT,
        ACT_RD_ROOT,
        ACT_REM_TOP,
        ACT_REM_LAST,
        ACT_RD_D,
        ACT_REM_LEFT,
        ACT_DOWN_MOVE,
        ACT_ST_FULL,
        ACT_ST_EMPTY
    } t_act;

    // Condition flags from the datapath to the sequencer.
    typedef struct packed {
        logic no_start;
        logic op_rem;
        logic full;
        logic empty;
        logic k_root;
        logic ins_gt;
        logic d_gt_cnt;
        logic rem_go;
        logic out_busy;
    } t_flags;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_act act;
        logic idle;
    } t_ctl;

endpackage

### rtl/hpq_mem.sv
// Heap entry storage: one write port and one registered read port.
module hpq_mem import hpq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_we,
    input  t_addr  i_waddr,
    input  t_entry i_wdata,
    input  t_addr  i_raddr,
    output t_entry o_rdata
);

    t_entry r_mem [CAPACITY+1];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hpq_seq.sv
// Microprogram sequencer: control store, step counter and conditional jumps.
module hpq_seq import hpq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    typedef logic [4:0] t_upc;

    // Program addresses. The result step sits just before the idle step so that
    // it falls through to idle once the result register is free.
    localparam t_upc U_EMIT      = 5'd0;
    localparam t_upc U_IDLE      = 5'd1;
    localparam t_upc U_DISP      = 5'd2;
    localparam t_upc U_INS0      = 5'd3;
    localparam t_upc U_INS1      = 5'd4;
    localparam t_upc U_INS_HEAD  = 5'd5;
    localparam t_upc U_INS_CMP   = 5'd6;
    localparam t_upc U_INS_PLACE = 5'd7;
    localparam t_upc U_REM0      = 5'd8;
    localparam t_upc U_REM1      = 5'd9;
    localparam t_upc U_REM2      = 5'd10;
    localparam t_upc U_REM_HEAD  = 5'd11;
    localparam t_upc U_REM_LEFT  = 5'd12;
    localparam t_upc U_REM_PICK  = 5'd13;
    localparam t_upc U_REM_PLACE = 5'd14;
    localparam t_upc U_ERR_FULL  = 5'd15;
    localparam t_upc U_ERR_EMPTY = 5'd16;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_OP_REM,
        C_FULL,
        C_EMPTY,
        C_K_ROOT,
        C_INS_GT,
        C_D_GT_CNT,
        C_REM_GO,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
    } t_uword;

    function automatic t_uword f_rom(input t_upc a);
        t_uword w;
        unique case (a)
            U_EMIT:      w = t_uword'{ACT_EMIT,      C_OUT_BUSY, U_EMIT};
            U_IDLE:      w = t_uword'{ACT_NONE,      C_NO_START, U_IDLE};
            U_DISP:      w = t_uword'{ACT_NONE,      C_OP_REM,   U_REM0};
            U_INS0:      w = t_uword'{ACT_NONE,      C_FULL,     U_ERR_FULL};
            U_INS1:      w = t_uword'{ACT_INS_START, C_NEXT,     U_IDLE};
            U_INS_HEAD:  w = t_uword'{ACT_RD_PARENT, C_K_ROOT,   U_INS_PLACE};
            U_INS_CMP:   w = t_uword'{ACT_UP_MOVE,   C_INS_GT,   U_INS_HEAD};
            U_INS_PLACE: w = t_uword'{ACT_WR_ENT,    C_ALWAYS,   U_EMIT};
            U_REM0:      w = t_uword'{ACT_RD_ROOT,   C_EMPTY,    U_ERR_EMPTY};
            U_REM1:      w = t_uword'{ACT_REM_TOP,   C_NEXT,     U_IDLE};
            U_REM2:      w = t_uword'{ACT_REM_LAST,  C_NEXT,     U_IDLE};
            U_REM_HEAD:  w = t_uword'{ACT_RD_D,      C_D_GT_CNT, U_REM_PLACE};
            U_REM_LEFT:  w = t_uword'{ACT_REM_LEFT,  C_NEXT,     U_IDLE};
            U_REM_PICK:  w = t_uword'{ACT_DOWN_MOVE, C_REM_GO,   U_REM_HEAD};
            U_REM_PLACE: w = t_uword'{ACT_WR_ENT,    C_ALWAYS,   U_EMIT};
            U_ERR_FULL:  w = t_uword'{ACT_ST_FULL,   C_ALWAYS,   U_EMIT};
            U_ERR_EMPTY: w = t_uword'{ACT_ST_EMPTY,  C_ALWAYS,   U_EMIT};
            default:     w = t_uword'{ACT_NONE,      C_ALWAYS,   U_IDLE};
        endcase
        return w;
    endfunction

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_cur;
    logic   w_take;

    always_comb begin
        w_cur = f_rom(r_upc);
        unique case (w_cur.cond)
            C_NEXT:     w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_START: w_take = i_flags.no_start;
            C_OP_REM:   w_take = i_flags.op_rem;
            C_FULL:     w_take = i_flags.full;
            C_EMPTY:    w_take = i_flags.empty;
            C_K_ROOT:   w_take = i_flags.k_root;
            C_INS_GT:   w_take = i_flags.ins_gt;
            C_D_GT_CNT: w_take = i_flags.d_gt_cnt;
            C_REM_GO:   w_take = i_flags.rem_go;
            C_OUT_BUSY: w_take = i_flags.out_busy;
            default:    w_take = 1'b0;
        endcase
        n_upc = w_take ? w_cur.target : t_upc'(r_upc + 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl.act  = w_cur.act;
    assign o_ctl.idle = (r_upc == U_IDLE);

endmodule

### rtl/max_heap_priority_queue.sv
// Max-heap priority queue top level: microcoded sift datapath around one entry memory.
// An insert sifts the new entry up toward the root and a removal sifts the last entry down
// toward a leaf; a rejected one only reports its status. One operation is worked at a time
// and the next transaction is taken in the cycle after its result loads, even while that
// result waits.
// Reset (synchronous, active low) empties the heap and clears the result valid; no sweep.
module max_heap_priority_queue import hpq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic signed [KEY_W-1:0] i_in_key,
    input  logic [PAY_W-1:0]        i_in_payload,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [KEY_W-1:0] o_out_key,
    output logic [PAY_W-1:0]        o_out_payload,
    output logic [1:0]              o_status,
    output logic [CNT_OUT_W-1:0]    o_entry_count,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    // Control from the microprogram and the condition flags back to it.
    t_ctl   w_ctl;
    t_flags w_flags;

    // Working registers of the datapath.
    t_cnt    r_count;     // entries held
    t_idx    r_k;         // hole index being moved up or down
    t_idx    r_d;         // left child index on the way down
    t_entry  r_ent;       // entry being placed (new entry or last entry)
    t_entry  r_top;       // removed root, zero for inserts and errors
    t_entry  r_child;     // left child captured on the way down
    logic    r_ge_left;   // moving entry not below the left child
    logic    r_op;        // operation of the transaction in progress
    t_status r_status;

    // Result register.
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic [PAY_W-1:0]        r_out_payload;
    t_status                 r_out_status;
    t_cnt                    r_out_cnt;
    logic                    r_out_empty;
    logic                    r_out_full;

    // Memory port.
    logic   w_we;
    t_addr  w_waddr;
    t_entry w_wdata;
    t_addr  w_raddr;
    t_entry w_rdata;

    logic   w_accept;
    logic   w_out_busy;
    logic   w_emit;
    t_idx   w_d_plus1;
    logic   w_use_right;
    logic   w_stop;
    t_idx   w_d_sel;
    t_entry w_sel_ent;
    logic   w_ins_gt;
    logic   w_full;
    logic   w_empty;

    hpq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    hpq_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A transaction is taken only while the sequencer sits at its idle step.
    assign o_in_stall = !w_ctl.idle;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_emit     = (w_ctl.act == ACT_EMIT) && !w_out_busy;

    // On the way down the two child keys and the moving key are compared in parallel;
    // the right child wins only when it exists and is strictly greater than the left.
    always_comb begin
        w_d_plus1   = t_idx'(r_d + 1'b1);
        w_use_right = (r_d < t_idx'(r_count)) &&
                      ($signed(r_child.key) < $signed(w_rdata.key));
        w_stop      = w_use_right ? ($signed(r_ent.key) >= $signed(w_rdata.key)) : r_ge_left;
        w_d_sel     = w_use_right ? w_d_plus1 : r_d;
        w_sel_ent   = w_use_right ? w_rdata : r_child;
        w_ins_gt    = $signed(r_ent.key) > $signed(w_rdata.key);
        w_full      = r_count >= t_cnt'(CAPACITY);
        w_empty     = r_count == '0;
    end

    always_comb begin
        w_flags.no_start = !w_accept;
        w_flags.op_rem   = r_op;
        w_flags.full     = w_full;
        w_flags.empty    = w_empty;
        w_flags.k_root   = r_k == t_idx'(1);
        w_flags.ins_gt   = w_ins_gt;
        w_flags.d_gt_cnt = r_d > t_idx'(r_count);
        w_flags.rem_go   = !w_stop;
        w_flags.out_busy = w_out_busy;
    end

    // Memory addressing per action. Read data is registered and appears in the cycle after the address.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k[AW-1:0];
        w_wdata = r_ent;
        w_raddr = '0;
        unique case (w_ctl.act)
            ACT_RD_PARENT: w_raddr = r_k[IW-1:1];
            ACT_RD_ROOT:   w_raddr = t_addr'(1);
            ACT_REM_TOP:   w_raddr = r_count;
            ACT_RD_D:      w_raddr = r_d[AW-1:0];
            ACT_REM_LEFT:  w_raddr = w_d_plus1[AW-1:0];
            ACT_UP_MOVE: begin
                // The smaller parent drops into the hole.
                w_we    = w_ins_gt;
                w_wdata = w_rdata;
            end
            ACT_WR_ENT: begin
                w_we = 1'b1;
            end
            ACT_DOWN_MOVE: begin
                // The larger child rises into the hole.
                w_we    = !w_stop;
                w_wdata = w_sel_ent;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Control state: count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.act == ACT_INS_START) begin
                r_count <= t_cnt'(r_count + 1'b1);
            end else if (w_ctl.act == ACT_REM_TOP) begin
                r_count <= t_cnt'(r_count - 1'b1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_operation;
            r_ent.key     <= i_in_key;
            r_ent.payload <= i_in_payload;
            r_top       <= '0;
            r_status    <= ST_OK;
        end
        unique case (w_ctl.act)
            ACT_INS_START: begin
                r_k <= t_idx'(r_count + 1'b1);
            end
            ACT_UP_MOVE: begin
                if (w_ins_gt) begin
                    r_k <= r_k >> 1;
                end
            end
            ACT_REM_TOP: begin
                r_top <= w_rdata;
                r_k   <= t_idx'(1);
                r_d   <= t_idx'(2);
            end
            ACT_REM_LAST: begin
                r_ent <= w_rdata;
            end
            ACT_REM_LEFT: begin
                r_child   <= w_rdata;
                r_ge_left <= $signed(r_ent.key) >= $signed(w_rdata.key);
            end
            ACT_DOWN_MOVE: begin
                if (!w_stop) begin
                    r_k <= w_d_sel;
                    r_d <= {w_d_sel[IW-2:0], 1'b0};
                end
            end
            ACT_ST_FULL: begin
                r_status <= ST_FULL;
            end
            ACT_ST_EMPTY: begin
                r_status <= ST_EMPTY;
            end
            ACT_EMIT: begin
                if (!w_out_busy) begin
                    r_out_key     <= r_top.key;
                    r_out_payload <= r_top.payload;
                    r_out_status  <= r_status;
                    r_out_cnt     <= r_count;
                    r_out_empty   <= w_empty;
                    r_out_full    <= r_count == t_cnt'(CAPACITY);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_status      = r_out_status;
    assign o_entry_count = CNT_OUT_W'(r_out_cnt);
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;

`ifndef ASSERT_OFF
    // Once a transaction is taken, the input side closes until its result is loaded.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // The heap never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("entry count beyond capacity");

    // A rejected insert reports a full heap.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> o_is_full)
        else $error("full status without full flag");

    // A removal from an empty heap reports an empty heap and a zero key.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_is_empty && (o_out_key == '0)))
        else $error("empty status with inconsistent result");
`endif

endmodule

### dv/tb_max_heap_priority_queue.sv
// Self-checking testbench for the max-heap priority queue: heap predictor, scoreboard, drivers.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;
    import hpq_pkg::*;

    // Operation codes on i_operation.
    localparam bit OP_INSERT = 1'b0;
    localparam bit OP_REMOVE = 1'b1;

    // Total number of transactions to offer in the run, the directed part included.
    localparam int ITEMS = 1200;
    // Transactions at the end of the run that are sent with no idling on either side.
    localparam int QUIET_TAIL = 120;
    // Long receiver hold-off, in cycles, that lets the block back up and stall its input.
    localparam int HOLD_CYCLES = 400;
    // The watchdog allows several times the sum of the slowest operation, one stall burst or
    // sender gap, and the long hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles to keep watching after the last expected result, to catch stray results.
    localparam int TAIL_CYCLES = 40;

    // One result, as the predictor expects to see it on the output ports.
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [1:0]              status;
        logic [CNT_OUT_W-1:0]    count;
        logic                    empty;
        logic                    full;
    } t_heap_result;

    // Keeps its own copy of the heap. Every accepted transaction is applied to that copy
    // and the result it should produce is queued. Results coming out of the block are
    // compared in order against that queue.
    class heap_scoreboard;
        t_entry       slots [0:CAPACITY];
        int unsigned  held;
        t_heap_result pending_q [$];
        int           errors;
        int           n_checked;
        int           n_full_rejects;
        int           n_empty_rejects;
        int unsigned  peak_held;

        function int pending();
            return pending_q.size();
        endfunction

        // Applies one accepted transaction to the heap copy and queues its result.
        function void note_input(bit op, logic signed [KEY_W-1:0] key,
                                 logic [PAY_W-1:0] payload);
            t_heap_result r;
            t_entry       e;
            t_entry       last;
            int unsigned  k;
            int unsigned  up;
            int unsigned  down;

            r.key     = '0;
            r.payload = '0;
            r.status  = ST_OK;
            if (op == OP_INSERT) begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                    n_full_rejects++;
                end else begin
                    // Sift up: pass only parents whose key is strictly smaller.
                    e.key     = key;
                    e.payload = payload;
                    held++;
                    k = held;
                    while (k != 1 && $signed(e.key) > $signed(slots[k/2].key)) begin
                        slots[k] = slots[k/2];
                        k = k / 2;
                    end
                    slots[k] = e;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_rejects++;
                end else begin
                    r.key     = slots[1].key;
                    r.payload = slots[1].payload;
                    last = slots[held];
                    held--;
                    up   = 1;
                    down = 2;
                    // Sift down toward the larger child; the left child wins a tie, and
                    // the moving entry stops when it is not smaller than that child.
                    while (down <= held) begin
                        if (down < held &&
                            $signed(slots[down].key) < $signed(slots[down+1].key)) begin
                            down++;
                        end
                        if ($signed(last.key) >= $signed(slots[down].key)) begin
                            break;
                        end
                        slots[up] = slots[down];
                        up   = down;
                        down = down * 2;
                    end
                    slots[up] = last;
                end
            end
            if (held > peak_held) begin
                peak_held = held;
            end
            r.count = held[CNT_OUT_W-1:0];
            r.empty = (held == 0);
            r.full  = (held == CAPACITY);
            pending_q.push_back(r);
        endfunction

        function void field_check(string what, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v,
                         act_v);
            end
        endfunction

        // Compares one result from the block with the oldest queued expectation.
        function void check_result(logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] payload,
                                   logic [1:0] status, logic [CNT_OUT_W-1:0] count,
                                   logic empty, logic full);
            t_heap_result r;

            n_checked++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing expected, expected none, actual key %0h",
                         $time, key);
                return;
            end
            r = pending_q.pop_front();
            field_check("out_key", 64'(unsigned'(r.key)), 64'(unsigned'(key)));
            field_check("out_payload", 64'(r.payload), 64'(payload));
            field_check("status", 64'(r.status), 64'(status));
            field_check("entry_count", 64'(r.count), 64'(count));
            field_check("is_empty", 64'(r.empty), 64'(empty));
            field_check("is_full", 64'(r.full), 64'(full));
        endfunction
    endclass

    // Clock, reset and every input of the block start at known values.
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    i_operation  = OP_INSERT;
    logic signed [KEY_W-1:0] i_in_key     = '0;
    logic [PAY_W-1:0]        i_in_payload = '0;
    logic                    i_out_stall  = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [KEY_W-1:0] o_out_key;
    logic [PAY_W-1:0]        o_out_payload;
    logic [1:0]              o_status;
    logic [CNT_OUT_W-1:0]    o_entry_count;
    logic                    o_is_empty;
    logic                    o_is_full;

    heap_scoreboard sb = new();

    // Idling controls shared by the sender and the receiver. A rate of zero gives a
    // stretch with no idling; quiet switches idling off for the tail of the run.
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  quiet       = 1'b0;
    bit  hold_req    = 1'b0;
    int  items_sent  = 0;
    int  idle_run    = 0;

    max_heap_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_in_key      (i_in_key),
        .i_in_payload  (i_in_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    always #10 i_clk = ~i_clk;

    // Keys lean on the extremes and on a handful of small values so that equal keys
    // meet often and the tie rules decide which payload comes out first.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return (int'($urandom_range(0, 3)) - 1) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Offers one transaction, after an optional idle burst, and returns at the edge that
    // accepts it. Valid stays high on return so that the next transaction can follow at
    // once; the payload is not touched while the block stalls.
    task automatic send_op(bit op, logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
        if (!quiet && tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_in_key     <= key;
        i_in_payload <= payload;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, key, payload);
        items_sent++;
    endtask

    task automatic send_random(int insert_pct);
        send_op(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE, pick_key(),
                16'($urandom_range(0, 16'hFFFF)));
    endtask

    // The sender goes quiet until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Receiver: checks each accepted result, then decides the stall for the next cycle.
    // A hold-off request from the stimulus gives one long stall counted here.
    initial begin
        int stall_left;
        int hold_left;

        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                sb.check_result(o_out_key, o_out_payload, o_status, o_entry_count,
                                o_is_empty, o_is_full);
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!quiet && rx_idle_pct > 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
                stall_left = $urandom_range(1, 17);
            end
            i_out_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    // Watchdog: ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_max_heap_priority_queue: done, errors");
            $finish;
        end
    end

    initial begin
        int phase_len;
        int insert_pct;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A removal on the empty heap comes first, then the key extremes,
        // zero and minus one, and the payload extremes.
        send_op(OP_REMOVE, 32'sh1234_5678, 16'hFFFF);
        send_op(OP_INSERT, 32'sh0000_0000, 16'h0000);
        send_op(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_op(OP_INSERT, 32'sh8000_0000, 16'h0001);
        send_op(OP_INSERT, -32'sd1, 16'h0002);
        // Three equal keys: an insert must not pass a parent with the same key.
        send_op(OP_INSERT, 32'sh0001_0000, 16'h0003);
        send_op(OP_INSERT, 32'sh0001_0000, 16'h0004);
        send_op(OP_INSERT, 32'sh0001_0000, 16'h0005);
        repeat (7) send_op(OP_REMOVE, '0, '0);
        // Removing one more than was held hits the empty case again.
        send_op(OP_REMOVE, '0, '0);
        // Equal keys on the way down: the left child wins a tie, and the moving entry
        // stops at a child with its own key.
        send_op(OP_INSERT, 32'sh0005_0000, 16'hA001);
        send_op(OP_INSERT, 32'sh0005_0000, 16'hA002);
        send_op(OP_INSERT, 32'sh0005_0000, 16'hA003);
        send_op(OP_INSERT, 32'sh0005_0000, 16'hA004);
        repeat (4) send_op(OP_REMOVE, '0, '0);
        wait_drained();

        // Fill the heap past capacity so that inserts get rejected as full, then drain
        // it past empty. The keys and payloads are random.
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        repeat (CAPACITY + 3) send_random(100);
        wait_drained();
        repeat (CAPACITY + 3) send_random(0);
        wait_drained();

        // Random phases: mixed traffic, filling runs and draining runs, each with its own
        // idling rates. Some phases have no idling at all. The first phase starts with a
        // long receiver hold-off while the sender keeps offering transactions.
        hold_req = 1'b1;
        while (items_sent < ITEMS) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 50;
                1: insert_pct = 85;
                default: insert_pct = 15;
            endcase
            tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            phase_len   = $urandom_range(40, 160);
            repeat (phase_len) begin
                if (items_sent >= ITEMS) begin
                    break;
                end
                if (items_sent >= ITEMS - QUIET_TAIL) begin
                    quiet = 1'b1;
                end
                send_random(insert_pct);
            end
            if (!quiet && $urandom_range(0, 1) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d operations and checked %0d results; peak occupancy %0d of %0d.",
                 items_sent, sb.n_checked, sb.peak_held, CAPACITY);
        $display("Rejected inserts on a full heap: %0d; removals on an empty heap: %0d.",
                 sb.n_full_rejects, sb.n_empty_rejects);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_max_heap_priority_queue: done, clean");
        end else begin
            $display("%0t ns: %0d mismatches, %0d results never arrived", $time, sb.errors,
                     sb.pending());
            $display("tb_max_heap_priority_queue: done, errors");
        end
        $finish;
    end

endmodule
